FILE: rtl/bpskcd_pkg.sv
// Shared constants, types and sine table function for the BPSK correlator demodulator.
`default_nettype none

package bpskcd_pkg;

    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int SINE_ADDR_BITS_DEF = 10;
    localparam int MAX_WINDOW         = 1024;

    localparam int PHASE_BITS    = 32;
    localparam int WIN_BITS      = 11;
    localparam int SINE_BITS     = 16;
    localparam int CORR_BITS     = 41;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    typedef logic [WIN_BITS-1:0]     t_win;

    localparam t_cfg_idx REG_PHASE_STEP = 2'd0;
    localparam t_cfg_idx REG_WIN_LEN    = 2'd1;

    localparam logic [PHASE_BITS-1:0] PHASE_STEP_RST = 32'h4000_0000;
    localparam t_win                  WIN_LEN_RST    = 11'd8;

    // Largest usable window: the register width caps it as well.
    localparam t_win WIN_CAP = WIN_BITS'((MAX_WINDOW > 2047) ? 2047 : MAX_WINDOW);

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;

    // Quarter-wave sine magnitude, Q1.15, for index m of a table with
    // 2^(addr_bits-2) steps per quarter. Evaluated at elaboration only.
    function automatic logic [SINE_BITS-2:0] quarter_sine(input int m, input int addr_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] q;
        logic [63:0] p;
        logic [63:0] s;
        x  = (64'(m) * PI_Q30 + (64'd1 << (addr_bits - 2))) >> (addr_bits - 1);
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        for (int i = 0; i < 5; i++) begin
            q = (x2 * t) >> 30;
            case (i)
                0:       p = q / 110;
                1:       p = q / 72;
                2:       p = q / 42;
                3:       p = q / 20;
                default: p = q / 6;
            endcase
            t = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        end
        s = (x * t) >> 30;
        s = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[SINE_BITS-2:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bpskcd_if.sv
// Valid/ready channel interfaces for samples in and decisions out.
`default_nettype none

interface bpskcd_smp_if #(
    parameter int SAMPLE_BITS = bpskcd_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] rx_sample;

    modport source (output valid, output rx_sample, input ready);
    modport sink   (input valid, input rx_sample, output ready);
endinterface

interface bpskcd_res_if;
    logic                                     valid;
    logic                                     ready;
    logic                                     hard_bit;
    logic signed [bpskcd_pkg::CORR_BITS-1:0]  correlation;

    modport source (output valid, output hard_bit, output correlation, input ready);
    modport sink   (input valid, input hard_bit, input correlation, output ready);
endinterface

`default_nettype wire

FILE: rtl/bpskcd_sine.sv
// Carrier sine lookup: quarter-wave table with quadrant folding.
`default_nettype none

module bpskcd_sine #(
    parameter int SINE_ADDR_BITS = bpskcd_pkg::SINE_ADDR_BITS_DEF
) (
    input  wire logic [bpskcd_pkg::PHASE_BITS-1:0]       i_phase,
    output logic signed [bpskcd_pkg::SINE_BITS-1:0]     o_sine
);

    localparam int QBITS = SINE_ADDR_BITS - 2;
    localparam int NQ    = 1 << QBITS;
    localparam logic [bpskcd_pkg::SINE_BITS-2:0] PEAK =
        bpskcd_pkg::quarter_sine(NQ, SINE_ADDR_BITS);

    logic [bpskcd_pkg::SINE_BITS-2:0] rom [NQ];

    for (genvar g = 0; g < NQ; g++) begin : g_rom
        localparam logic [bpskcd_pkg::SINE_BITS-2:0] V =
            bpskcd_pkg::quarter_sine(g, SINE_ADDR_BITS);
        assign rom[g] = V;
    end

    logic [1:0]                       quad;
    logic [QBITS-1:0]                 k;
    logic [QBITS-1:0]                 idx;
    logic [bpskcd_pkg::SINE_BITS-2:0] mag;

    assign quad = i_phase[bpskcd_pkg::PHASE_BITS-1 -: 2];
    assign k    = i_phase[bpskcd_pkg::PHASE_BITS-3 -: QBITS];
    // Odd quadrants run the table backward: N - k, folded into QBITS bits.
    assign idx  = quad[0] ? QBITS'(-k) : k;

    always_comb begin
        if (quad[0] && (k == '0)) begin
            mag = PEAK;
        end else begin
            mag = rom[idx];
        end
        if (quad[1]) begin
            o_sine = -$signed({1'b0, mag});
        end else begin
            o_sine = $signed({1'b0, mag});
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bpskcd_seq.sv
// Configuration registers, carrier phase, window counter and input stage.
`default_nettype none

module bpskcd_seq #(
    parameter int SAMPLE_BITS    = bpskcd_pkg::SAMPLE_BITS_DEF,
    parameter int SINE_ADDR_BITS = bpskcd_pkg::SINE_ADDR_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire bpskcd_pkg::t_cfg_idx                  i_cfg_idx,
    input  wire logic [bpskcd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    bpskcd_smp_if.sink                                 i_smp,
    input  wire logic                                  i_mac_ready,
    output bpskcd_pkg::t_ctl                           o_ctl,
    output logic signed [SAMPLE_BITS-1:0]              o_sample,
    output logic signed [bpskcd_pkg::SINE_BITS-1:0]    o_sine
);

    logic [bpskcd_pkg::PHASE_BITS-1:0]          r_phase_step;
    bpskcd_pkg::t_win                           r_win_len;
    logic [bpskcd_pkg::PHASE_BITS-1:0]          r_phase;
    bpskcd_pkg::t_win                           r_pos;
    logic                                       r_valid;
    logic                                       r_last;
    logic signed [SAMPLE_BITS-1:0]              r_sample;
    logic signed [bpskcd_pkg::SINE_BITS-1:0]    r_sine;

    logic signed [bpskcd_pkg::SINE_BITS-1:0]    sine;
    bpskcd_pkg::t_win                           len_eff;
    bpskcd_pkg::t_win                           pos_inc;
    logic                                       last;
    logic                                       ready;
    logic                                       accept;

    bpskcd_sine #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_sine (
        .i_phase (r_phase),
        .o_sine  (sine)
    );

    always_comb begin
        if (r_win_len == '0) begin
            len_eff = bpskcd_pkg::t_win'(1);
        end else if (r_win_len > bpskcd_pkg::WIN_CAP) begin
            len_eff = bpskcd_pkg::WIN_CAP;
        end else begin
            len_eff = r_win_len;
        end
    end

    assign pos_inc = r_pos + bpskcd_pkg::t_win'(1);
    assign last    = (pos_inc >= len_eff);
    assign ready   = !r_valid || i_mac_ready;
    assign accept  = i_smp.valid && ready;

    assign i_smp.ready = ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= bpskcd_pkg::PHASE_STEP_RST;
            r_win_len    <= bpskcd_pkg::WIN_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bpskcd_pkg::REG_PHASE_STEP: r_phase_step <= i_cfg_data;
                bpskcd_pkg::REG_WIN_LEN:    r_win_len    <= i_cfg_data[bpskcd_pkg::WIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_pos   <= '0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else if (accept) begin
            r_phase <= r_phase + r_phase_step;
            r_pos   <= last ? '0 : pos_inc;
            r_valid <= 1'b1;
            r_last  <= last;
        end else if (i_mac_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset; sine is taken at the phase of this item.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_smp.rx_sample;
            r_sine   <= sine;
        end
    end

    assign o_ctl.valid = r_valid;
    assign o_ctl.last  = r_last;
    assign o_sample    = r_sample;
    assign o_sine      = r_sine;

endmodule

`default_nettype wire

FILE: rtl/bpskcd_mac.sv
// Multiply stage, saturating integrator and decision output register.
`default_nettype none

module bpskcd_mac #(
    parameter int SAMPLE_BITS = bpskcd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire bpskcd_pkg::t_ctl                      i_ctl,
    input  wire logic signed [SAMPLE_BITS-1:0]         i_sample,
    input  wire logic signed [bpskcd_pkg::SINE_BITS-1:0] i_sine,
    output logic                                       o_ready,
    bpskcd_res_if.source                               o_res
);

    localparam int PROD_BITS = SAMPLE_BITS + bpskcd_pkg::SINE_BITS;
    localparam int CB        = bpskcd_pkg::CORR_BITS;

    logic                         r_b_valid;
    logic                         r_b_last;
    logic signed [PROD_BITS-1:0]  r_prod;
    logic signed [CB-1:0]         r_acc;
    logic                         r_out_valid;
    logic                         r_hard;
    logic signed [CB-1:0]         r_corr;

    logic                         b_ready;
    logic                         out_free;
    logic                         c_take;
    logic signed [CB:0]           sum;
    logic signed [CB-1:0]         sat;

    assign out_free = !r_out_valid || o_res.ready;
    // Only a window-closing item needs the output register.
    assign c_take   = r_b_valid && (!r_b_last || out_free);
    assign b_ready  = !r_b_valid || c_take;
    assign o_ready  = b_ready;

    assign sum = (CB + 1)'(r_acc) + (CB + 1)'(r_prod);

    always_comb begin
        if (sum[CB] != sum[CB-1]) begin
            sat = sum[CB] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
        end else begin
            sat = sum[CB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_last  <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= i_ctl.valid;
            r_b_last  <= i_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && i_ctl.valid) begin
            r_prod <= i_sample * i_sine;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (c_take) begin
                r_acc <= r_b_last ? '0 : sat;
            end
            if (c_take && r_b_last) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_take && r_b_last) begin
            r_corr <= sat;
            r_hard <= sat[CB-1];
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.hard_bit    = r_hard;
    assign o_res.correlation = r_corr;

endmodule

`default_nettype wire

FILE: rtl/bpsk_correlator_demodulator.sv
// Top level of the BPSK coherent integrate-and-dump demodulator.
//
//  channel  | direction | payload                         | handshake
//  ---------+-----------+---------------------------------+--------------------------
//  i_smp    | in        | rx_sample (SAMPLE_BITS, signed) | valid/ready
//  o_res    | out       | hard_bit, correlation (41, s)   | valid/ready
//  i_cfg_*  | in        | index 0 phase_step, 1 win_len   | write on i_cfg_we
//
// One sample per clock is taken unless the input stalls; the sample that closes a
// window yields its decision through the input register, the multiplier register
// and the integrator/output register. The input stalls only while a finished
// decision sits unread and the pipeline behind it has filled.
// Synchronous reset clears phase, window count, integrator and all valids.
`default_nettype none

module bpsk_correlator_demodulator #(
    parameter int SAMPLE_BITS    = bpskcd_pkg::SAMPLE_BITS_DEF,
    parameter int SINE_ADDR_BITS = bpskcd_pkg::SINE_ADDR_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire bpskcd_pkg::t_cfg_idx                  i_cfg_idx,
    input  wire logic [bpskcd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    bpskcd_smp_if.sink                                 i_smp,
    bpskcd_res_if.source                               o_res
);

    bpskcd_pkg::t_ctl                         ctl;
    logic signed [SAMPLE_BITS-1:0]            sample;
    logic signed [bpskcd_pkg::SINE_BITS-1:0]  sine;
    logic                                     mac_ready;

    bpskcd_seq #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_smp       (i_smp),
        .i_mac_ready (mac_ready),
        .o_ctl       (ctl),
        .o_sample    (sample),
        .o_sine      (sine)
    );

    bpskcd_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_sample (sample),
        .i_sine   (sine),
        .o_ready  (mac_ready),
        .o_res    (o_res)
    );

endmodule

`default_nettype wire

FILE: rtl/bpskcd_checker.sv
// Port-level checks for the demodulator, bound to the top level.
`default_nettype none

module bpskcd_checker (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_in_ready,
    input wire logic                                 i_out_valid,
    input wire logic                                 i_out_ready,
    input wire logic                                 i_hard_bit,
    input wire logic [bpskcd_pkg::CORR_BITS-1:0]     i_correlation
);

    // Hold a stalled decision unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_correlation)
            && $stable(i_hard_bit))
        else $error("stalled decision changed");

    a_bit_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_hard_bit == i_correlation[bpskcd_pkg::CORR_BITS-1])
        else $error("hard bit disagrees with correlation sign");

    // Input back-pressure only comes from an unread decision.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without output back-pressure");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("decision valid right after reset");

endmodule

bind bpsk_correlator_demodulator bpskcd_checker u_bpskcd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_smp.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_hard_bit    (o_res.hard_bit),
    .i_correlation (o_res.correlation)
);

`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the BPSK correlator demodulator: random samples, checked decisions.
module tb;

    typedef bpskcd_pkg::t_cfg_idx t_cfg_idx;
    typedef bpskcd_pkg::t_win     t_win;

    localparam int          SMP_W       = bpskcd_pkg::SAMPLE_BITS_DEF;
    localparam int          TBL_BITS    = bpskcd_pkg::SINE_ADDR_BITS_DEF;
    localparam int          TBL_SIZE    = 1 << TBL_BITS;
    localparam int          QTR_STEPS   = 1 << (TBL_BITS - 2);
    localparam int          PH_BITS     = bpskcd_pkg::PHASE_BITS;
    localparam int          CORR_W      = bpskcd_pkg::CORR_BITS;
    localparam int          DATA_W      = bpskcd_pkg::CFG_DATA_BITS;
    localparam int          LEN_W       = bpskcd_pkg::WIN_BITS;
    localparam int          WIN_MAX     = bpskcd_pkg::MAX_WINDOW;
    localparam logic [63:0] PI_SCALED   = 64'd3373259426;
    localparam logic [63:0] UNIT_SCALED = 64'd1 << 30;
    localparam longint      CORR_TOP    = (longint'(1) <<< (CORR_W - 1)) - 1;
    localparam longint      CORR_BOTTOM = -CORR_TOP - 1;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          SETTLE      = 8;

    localparam t_cfg_idx REG_PHASE_STEP = bpskcd_pkg::REG_PHASE_STEP;
    localparam t_cfg_idx REG_WIN_LEN    = bpskcd_pkg::REG_WIN_LEN;
    // Indexes past the register list; writes there must do nothing.
    localparam t_cfg_idx REG_SPARE_2 = 2'd2;
    localparam t_cfg_idx REG_SPARE_3 = 2'd3;

    typedef logic signed [SMP_W-1:0] t_sample;

    localparam t_sample SMP_MAX = t_sample'((1 << (SMP_W - 1)) - 1);
    localparam t_sample SMP_MIN = t_sample'(1 << (SMP_W - 1));

    typedef struct {
        logic              hard;
        logic [CORR_W-1:0] corr;
    } t_decision;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    t_cfg_idx          i_cfg_idx;
    logic [DATA_W-1:0] i_cfg_data;

    bpskcd_smp_if smp_ch ();
    bpskcd_res_if res_ch ();

    bpsk_correlator_demodulator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_smp      (smp_ch),
        .o_res      (res_ch)
    );

    // Demodulator shadow: carrier table, registers and running state.
    int                 carrier_tbl [TBL_SIZE];
    logic [PH_BITS-1:0] step_reg  = bpskcd_pkg::PHASE_STEP_RST;
    t_win               len_reg   = bpskcd_pkg::WIN_LEN_RST;
    logic [PH_BITS-1:0] phase_acc = '0;
    longint             corr_sum  = 0;
    t_win               win_fill  = '0;

    t_sample   pending_samples [$];
    t_decision decisions_due [$];

    bit src_idle_on = 1'b0;
    bit snk_idle_on = 1'b0;
    int send_gap;
    int recv_gap;
    int hold_left;
    int holds_done;
    int hold_requests = 0;
    int mismatches = 0;
    int cycle_count = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int quarter_mag(int unsigned idx);
        logic [63:0] ang;
        logic [63:0] ang_sq;
        logic [63:0] term;
        logic [63:0] prod;
        logic [63:0] mag;
        ang    = (64'(idx) * PI_SCALED + (64'd1 << (TBL_BITS - 2))) >> (TBL_BITS - 1);
        ang_sq = (ang * ang) >> 30;
        term   = UNIT_SCALED;
        // Horner from the x^11 term down; divisor of stage k is 2k(2k+1).
        for (int k = 5; k >= 1; k--) begin
            prod = ((ang_sq * term) >> 30) / 64'(2 * k * (2 * k + 1));
            term = (prod >= UNIT_SCALED) ? 64'd0 : UNIT_SCALED - prod;
        end
        mag = (ang * term) >> 30;
        mag = (mag + 64'd16384) >> 15;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        return int'(mag);
    endfunction

    task automatic integrate_sample(input t_sample smp);
        longint    total;
        int        span;
        t_decision due;
        span = (len_reg == '0) ? 1 : int'(len_reg);
        if (span > WIN_MAX) begin
            span = WIN_MAX;
        end
        total = corr_sum
              + longint'(smp) * longint'(carrier_tbl[phase_acc[PH_BITS-1 -: TBL_BITS]]);
        if (total > CORR_TOP) begin
            total = CORR_TOP;
        end
        if (total < CORR_BOTTOM) begin
            total = CORR_BOTTOM;
        end
        corr_sum  = total;
        phase_acc = phase_acc + step_reg;
        win_fill  = win_fill + 1'b1;
        if (int'(win_fill) >= span) begin
            due.hard = (total < 0);
            due.corr = total[CORR_W-1:0];
            decisions_due.push_back(due);
            corr_sum = 0;
            win_fill = '0;
        end
    endtask

    function automatic t_sample pick_sample();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            return SMP_MIN;
        end
        if (r == 1) begin
            return SMP_MAX;
        end
        if (r < 4) begin
            return t_sample'(int'($urandom_range(0, 255)) - 128);
        end
        return t_sample'($urandom);
    endfunction

    function automatic logic [PH_BITS-1:0] pick_step();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return '1;
            2:       return 32'h4000_0000;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_win pick_len();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end
        if (r < 7) begin
            return t_win'($urandom_range(1, 12));
        end
        return t_win'($urandom_range(13, 48));
    endfunction

    // Drive one register write, mirror it, and return at a falling edge.
    task automatic write_reg(input t_cfg_idx idx, input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_PHASE_STEP) begin
            step_reg = val[PH_BITS-1:0];
        end else if (idx == REG_WIN_LEN) begin
            len_reg = val[LEN_W-1:0];
        end
        @(negedge i_clk);
    endtask

    // Upper data bits are noise; only the low bits land in the length register.
    task automatic write_len(input t_win len);
        write_reg(REG_WIN_LEN, {(DATA_W - LEN_W)'($urandom), len});
    endtask

    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (pending_samples.size() != 0 || smp_ch.valid || decisions_due.size() != 0);
        // A window may still be open; let the pipeline drain its last samples.
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_idling(input bit src_on, input bit snk_on);
        @(negedge i_clk);
        src_idle_on = src_on;
        snk_idle_on = snk_on;
    endtask

    task automatic offer_random(input int count);
        @(negedge i_clk);
        repeat (count) pending_samples.push_back(pick_sample());
    endtask

    always @(posedge i_clk) begin : drive_samples
        logic    next_valid;
        t_sample next_smp;
        if (!i_rst_n) begin
            smp_ch.valid     <= 1'b0;
            smp_ch.rx_sample <= '0;
            send_gap = 0;
        end else begin
            if (smp_ch.valid && smp_ch.ready) begin
                integrate_sample(smp_ch.rx_sample);
            end
            if (!smp_ch.valid || smp_ch.ready) begin
                next_valid = 1'b0;
                next_smp   = smp_ch.rx_sample;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (src_idle_on && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 8);
                end else if (pending_samples.size() != 0) begin
                    next_valid = 1'b1;
                    next_smp   = pending_samples.pop_front();
                end
                smp_ch.valid     <= next_valid;
                smp_ch.rx_sample <= next_smp;
            end
        end
    end

    always @(posedge i_clk) begin : check_decisions
        t_decision due;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (decisions_due.size() == 0) begin
                    $error("decision with none expected: hard_bit %0d, correlation %0d",
                           res_ch.hard_bit, $signed(res_ch.correlation));
                    mismatches++;
                end else begin
                    due = decisions_due.pop_front();
                    if (res_ch.hard_bit !== due.hard) begin
                        $error("hard_bit: expected %0d, got %0d", due.hard, res_ch.hard_bit);
                        mismatches++;
                    end
                    if (res_ch.correlation !== due.corr) begin
                        $error("correlation: expected %0d, got %0d",
                               $signed(due.corr), $signed(res_ch.correlation));
                        mismatches++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
            end else if (snk_idle_on && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(1, 9);
            end
            res_ch.ready <= (recv_gap == 0) && (hold_left == 0);
        end
    end

    // Long back-pressure on the decision side, started on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            holds_done <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done != hold_requests) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= hold_requests;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bpsk_correlator_demodulator test failed");
            $finish;
        end
    end

    initial begin : run_test
        int quad;
        int off;
        int mag;
        int rounds;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= REG_PHASE_STEP;
        i_cfg_data <= '0;

        for (int a = 0; a < TBL_SIZE; a++) begin
            quad = a >> (TBL_BITS - 2);
            off  = a & (QTR_STEPS - 1);
            mag  = quarter_mag((quad & 1) ? QTR_STEPS - off : off);
            carrier_tbl[a] = (quad & 2) ? -mag : mag;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: quarter-cycle steps hit zero and both sine peaks.
        set_idling(1'b1, 1'b1);
        pending_samples.push_back(SMP_MAX);
        pending_samples.push_back(SMP_MIN);
        pending_samples.push_back(SMP_MIN);
        pending_samples.push_back(SMP_MAX);
        pending_samples.push_back(t_sample'(-1));
        pending_samples.push_back(t_sample'(1));
        pending_samples.push_back(t_sample'(16'h5555));
        pending_samples.push_back(t_sample'(16'hAAAA));
        wait_idle();

        // Zero length acts as one; spare indexes must not disturb anything.
        write_reg(REG_PHASE_STEP, 32'h1234_5679);
        write_len('0);
        write_reg(REG_SPARE_2, $urandom);
        write_reg(REG_SPARE_3, $urandom);
        pending_samples.push_back(SMP_MAX);
        pending_samples.push_back(SMP_MIN);
        pending_samples.push_back('0);
        pending_samples.push_back(t_sample'(-2));
        wait_idle();

        // Land the carrier on its positive peak, then freeze it there.
        write_len(t_win'(1));
        write_reg(REG_PHASE_STEP, 32'h4000_0000 - phase_acc);
        pending_samples.push_back(SMP_MAX);
        wait_idle();

        // Oversized length acts as the maximum; a shorter one then closes the window.
        write_reg(REG_PHASE_STEP, '0);
        write_len('1);
        set_idling(1'b0, 1'b0);
        repeat (5) pending_samples.push_back(SMP_MIN);
        wait_idle();
        write_len(t_win'(3));
        pending_samples.push_back(SMP_MAX);
        wait_idle();

        // Shrink the length below the current fill: next sample closes the window.
        write_reg(REG_PHASE_STEP, '1);
        write_len(t_win'(WIN_MAX));
        set_idling(1'b1, 1'b1);
        repeat (5) pending_samples.push_back(pick_sample());
        wait_idle();
        write_len(t_win'(3));
        pending_samples.push_back(SMP_MAX);
        wait_idle();

        rounds = 10;
        for (int r = 0; r < rounds; r++) begin
            write_reg(REG_PHASE_STEP, pick_step());
            write_len(pick_len());
            if ($urandom_range(0, 3) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, $urandom);
            end
            if (r == 2) begin
                // Fill the block against a stalled output with a steady input.
                write_len(t_win'(2));
                set_idling(1'b0, 1'b0);
                hold_requests++;
                offer_random(150);
            end else if (r == rounds - 1) begin
                set_idling(1'b0, 1'b0);
                offer_random(40);
            end else begin
                set_idling($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
                offer_random(40);
            end
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (decisions_due.size() != 0) begin
            $error("%0d decisions never arrived", decisions_due.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("bpsk_correlator_demodulator test passed");
        end else begin
            $display("bpsk_correlator_demodulator test failed");
        end
        $finish;
    end
endmodule

FILE: bpsk_correlator_demodulator.f
rtl/bpskcd_pkg.sv
rtl/bpskcd_if.sv
rtl/bpskcd_sine.sv
rtl/bpskcd_seq.sv
rtl/bpskcd_mac.sv
rtl/bpsk_correlator_demodulator.sv
rtl/bpskcd_checker.sv
test/tb.sv
